@@ hdl/tse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tse_pkg
// Shared constants, types and helper functions of the tricubic spline
// evaluator.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int MAX_XY_CELLS   = 16;
    localparam int MAX_Z_CELLS    = 8;
    localparam int FRAC_BITS      = 16;

    localparam int COEFS_PER_CELL = 64;
    localparam int COEF_IW        = $clog2(COEFS_PER_CELL);

    localparam int POS_W   = 24;
    localparam int COEF_W  = 32;
    localparam int IDX_W   = 17;
    localparam int OUT_W   = 42;
    localparam int XY_CFG_W = 5;
    localparam int Z_CFG_W  = 4;

    // Widths of cell counts and cell indexes.
    localparam int XY_CW = $clog2(MAX_XY_CELLS + 1);
    localparam int Z_CW  = $clog2(MAX_Z_CELLS + 1);
    localparam int XY_IW = (MAX_XY_CELLS > 1) ? $clog2(MAX_XY_CELLS) : 1;
    localparam int Z_IW  = (MAX_Z_CELLS > 1) ? $clog2(MAX_Z_CELLS) : 1;
    localparam int XY_W  = (MAX_XY_CELLS > 1) ? $clog2(MAX_XY_CELLS * MAX_XY_CELLS) : 1;
    localparam int CELL_W = (MAX_XY_CELLS * MAX_XY_CELLS * MAX_Z_CELLS > 1) ?
                            $clog2(MAX_XY_CELLS * MAX_XY_CELLS * MAX_Z_CELLS) : 1;
    localparam int ADDR_W      = CELL_W + COEF_IW;
    localparam int STORE_DEPTH = MAX_XY_CELLS * MAX_XY_CELLS * MAX_Z_CELLS * COEFS_PER_CELL;
    localparam int RAM_DEPTH   = 2 ** ADDR_W;

    // Fixed-point widths: powers and monomials reach 1.0, weights reach 3.0.
    localparam int P_W    = FRAC_BITS + 1;
    localparam int W_W    = FRAC_BITS + 2;
    localparam int PROD_W = COEF_W + W_W + 1;
    localparam int ACC_W  = OUT_W + FRAC_BITS;

    localparam logic [P_W-1:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Request kinds carried in tuser.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_X_CELLS = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_Y_CELLS = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_Z_CELLS = 2'd2;

    // Steps of the power setup sequence.
    localparam logic [2:0] PS_SQ_X = 3'd0;
    localparam logic [2:0] PS_SQ_Y = 3'd1;
    localparam logic [2:0] PS_SQ_Z = 3'd2;
    localparam logic [2:0] PS_CU_X = 3'd3;
    localparam logic [2:0] PS_CU_Y = 3'd4;
    localparam logic [2:0] PS_CU_Z = 3'd5;

    // Last counts of the drain through the register stages after a memory read, and of the coefficient sweep.
    localparam logic [COEF_IW-1:0] DRAIN_LAST = COEF_IW'(2);
    localparam logic [COEF_IW-1:0] COEF_LAST  = COEF_IW'(COEFS_PER_CELL - 1);

    typedef struct packed {
        logic                latch;
        logic                ram_we;
        logic                loc;
        logic                prep;
        logic [2:0]          pstep;
        logic                issue;
        logic [COEF_IW-1:0]  idx;
        logic                out_load;
    } tse_cmd_t;

    typedef struct packed {
        logic [7:0]           cell_idx;
        logic [FRAC_BITS-1:0] frac;
    } tse_loc_t;

    // A count of zero acts as one, a count above the maximum acts as the maximum.
    function automatic logic [7:0] eff_cells(input logic [7:0] r, input logic [7:0] maxv);
        logic [7:0] n;
        begin
            n = r;
            if (r == 8'd0)
            begin
                n = 8'd1;
            end
            else if (r > maxv)
            begin
                n = maxv;
            end
            return n;
        end
    endfunction

    // Clamp a coordinate to [0, n] cells and split it into cell and fraction.
    function automatic tse_loc_t locate(input logic [POS_W-1:0] pos, input logic [7:0] n);
        logic [POS_W+7:0] lim;
        logic [POS_W+7:0] p;
        tse_loc_t         res;
        begin
            lim = {{POS_W{1'b0}}, n} << FRAC_BITS;
            p   = {8'd0, pos};
            if (p > lim)
            begin
                p = lim;
            end
            res.cell_idx = p[FRAC_BITS+7:FRAC_BITS];
            res.frac     = p[FRAC_BITS-1:0];
            if (res.cell_idx >= n)
            begin
                res.cell_idx = n - 8'd1;
            end
            return res;
        end
    endfunction

    function automatic logic [P_W-1:0] pow_sel(input logic [1:0] e,
                                               input logic [FRAC_BITS-1:0] d,
                                               input logic [FRAC_BITS-1:0] sq,
                                               input logic [FRAC_BITS-1:0] cu);
        logic [P_W-1:0] r;
        begin
            case (e)
                2'd0:    r = FX_ONE;
                2'd1:    r = {1'b0, d};
                2'd2:    r = {1'b0, sq};
                default: r = {1'b0, cu};
            endcase
            return r;
        end
    endfunction

    // Multiply a monomial by an exponent of 0..3 with one add.
    function automatic logic [W_W-1:0] times_exp(input logic [P_W-1:0] m,
                                                 input logic [1:0] e);
        logic [W_W-1:0] a;
        logic [W_W-1:0] b;
        begin
            a = e[0] ? {1'b0, m} : '0;
            b = e[1] ? {m, 1'b0} : '0;
            return a + b;
        end
    endfunction

endpackage
`default_nettype wire

@@ hdl/tricubic_spline_eval_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tricubic_spline_eval_top
// Tricubic spline evaluator with a coefficient memory: load requests store one
// coefficient, evaluate requests return the value and three derivatives.
// ----------------------------------------------------------------------------
// A load request is written in the cycle it is taken. An evaluate request shows
// m_tvalid after a locate, 6 power steps, 64 coefficient reads from the
// single-port memory, 3 pipeline stages and an output load.
// s_tready returns with the result, so a new evaluate is taken only once the last is done.
// Reset clears the control state and sets the cell counts to 16, 16 and 8;
// the coefficient memory is not cleared.
module tricubic_spline_eval_top
    import tse_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // [16:0] coeff_index, [48:17] coeff_value, [72:49] x_pos, [96:73] y_pos,
    // [120:97] z_pos, [127:121] zero
    input  wire logic [127:0]       s_tdata,
    // [0] req_type
    input  wire logic               s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [41:0] spline_value, [83:42] deriv_x, [125:84] deriv_y, [167:126] deriv_z
    output logic [167:0]            m_tdata,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_IW-1:0]  cfg_index,
    input  wire logic [4:0]         cfg_data
);

    logic [XY_CFG_W-1:0] x_cells_reg;
    logic [XY_CFG_W-1:0] y_cells_reg;
    logic [Z_CFG_W-1:0]  z_cells_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_cells_reg <= XY_CFG_W'(16);
            y_cells_reg <= XY_CFG_W'(16);
            z_cells_reg <= Z_CFG_W'(8);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_X_CELLS: x_cells_reg <= cfg_data[XY_CFG_W-1:0];
                CFG_Y_CELLS: y_cells_reg <= cfg_data[XY_CFG_W-1:0];
                CFG_Z_CELLS: z_cells_reg <= cfg_data[Z_CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tse_cmd_t cmd;

    tse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tse_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .x_cells      (x_cells_reg),
        .y_cells      (y_cells_reg),
        .z_cells      (z_cells_reg),
        .coeff_index  (s_tdata[16:0]),
        .coeff_value  (s_tdata[48:17]),
        .x_pos        (s_tdata[72:49]),
        .y_pos        (s_tdata[96:73]),
        .z_pos        (s_tdata[120:97]),
        .spline_value (m_tdata[41:0]),
        .deriv_x      (m_tdata[83:42]),
        .deriv_y      (m_tdata[125:84]),
        .deriv_z      (m_tdata[167:126])
    );

`ifndef SYNTHESIS
    // An evaluate transaction occupies the block until its result is registered.
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_EVAL)) |=> !s_tready)
        else $error("input accepted again right after an evaluate request");

    // A load completes in its own cycle and leaves the block ready.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_LOAD)) |=> s_tready)
        else $error("load request left the block busy");

    // Memory writes happen only when a request is taken in the idle state.
    a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_we |-> (s_tready && s_tvalid && !cmd.issue))
        else $error("coefficient write outside an idle load transaction");

    // A new result never replaces one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && m_tvalid) |-> m_tready)
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

@@ hdl/tse_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tse_ram
// Generic single-port RAM with one write or read per cycle and registered
// read data.
// ----------------------------------------------------------------------------
module tse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

@@ hdl/tse_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tse_ctrl
// Sequencer of the evaluator: accepts requests, steps through locate, power
// setup, the coefficient sweep and pipeline drain, and owns the output valid.
// ----------------------------------------------------------------------------
module tse_ctrl
    import tse_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    input  wire logic  s_tuser,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output tse_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOC   = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [COEF_IW-1:0] cnt_reg;
    logic [COEF_IW-1:0] cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.pstep      = cnt_reg[2:0];
        cmd.idx        = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == REQ_EVAL)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = ST_LOC;
                    end
                    else
                    begin
                        cmd.ram_we = 1'b1;
                    end
                end
            end
            ST_LOC:
            begin
                cmd.loc    = 1'b1;
                cnt_next   = '0;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                if (cnt_reg[2:0] == PS_CU_Z)
                begin
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == COEF_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == DRAIN_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                // The output register frees up in the cycle its transaction completes.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

@@ hdl/tse_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tse_dp
// Datapath of the evaluator: coordinate locate, power setup on a shared
// multiplier, coefficient memory, monomial and weight pipeline, and four
// accumulators feeding the output register.
// ----------------------------------------------------------------------------
module tse_dp
    import tse_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tse_cmd_t                     cmd,
    input  wire logic [XY_CFG_W-1:0]          x_cells,
    input  wire logic [XY_CFG_W-1:0]          y_cells,
    input  wire logic [Z_CFG_W-1:0]           z_cells,
    input  wire logic [IDX_W-1:0]             coeff_index,
    input  wire logic signed [COEF_W-1:0]     coeff_value,
    input  wire logic [POS_W-1:0]             x_pos,
    input  wire logic [POS_W-1:0]             y_pos,
    input  wire logic [POS_W-1:0]             z_pos,
    output logic signed [OUT_W-1:0]           spline_value,
    output logic signed [OUT_W-1:0]           deriv_x,
    output logic signed [OUT_W-1:0]           deriv_y,
    output logic signed [OUT_W-1:0]           deriv_z
);

    // Request and locate registers.
    logic [POS_W-1:0]     xpos_reg;
    logic [POS_W-1:0]     ypos_reg;
    logic [POS_W-1:0]     zpos_reg;
    logic [XY_IW-1:0]     xc_reg;
    logic [XY_IW-1:0]     yc_reg;
    logic [Z_IW-1:0]      zc_reg;
    logic [FRAC_BITS-1:0] dx_reg;
    logic [FRAC_BITS-1:0] dy_reg;
    logic [FRAC_BITS-1:0] dz_reg;
    logic [FRAC_BITS-1:0] sqx_reg;
    logic [FRAC_BITS-1:0] sqy_reg;
    logic [FRAC_BITS-1:0] sqz_reg;
    logic [FRAC_BITS-1:0] cux_reg;
    logic [FRAC_BITS-1:0] cuy_reg;
    logic [FRAC_BITS-1:0] cuz_reg;
    logic [XY_W-1:0]      xy_reg;
    logic [CELL_W-1:0]    cell_reg;

    logic [7:0]           nx;
    logic [7:0]           ny;
    logic [7:0]           nz;
    tse_loc_t             lx;
    tse_loc_t             ly;
    tse_loc_t             lz;

    logic [FRAC_BITS-1:0]   mul_a;
    logic [FRAC_BITS-1:0]   mul_b;
    logic [2*FRAC_BITS-1:0] mul_p;
    logic [FRAC_BITS-1:0]   mul_r;
    logic [XY_IW+XY_CW:0]   xy_full;
    logic [XY_W+Z_CW:0]     cell_full;

    assign nx = eff_cells(8'(x_cells), 8'(MAX_XY_CELLS));
    assign ny = eff_cells(8'(y_cells), 8'(MAX_XY_CELLS));
    assign nz = eff_cells(8'(z_cells), 8'(MAX_Z_CELLS));
    assign lx = locate(xpos_reg, nx);
    assign ly = locate(ypos_reg, ny);
    assign lz = locate(zpos_reg, nz);

    always_comb
    begin
        case (cmd.pstep)
            PS_SQ_X:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            PS_SQ_Y:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            PS_SQ_Z:
            begin
                mul_a = dz_reg;
                mul_b = dz_reg;
            end
            PS_CU_X:
            begin
                mul_a = sqx_reg;
                mul_b = dx_reg;
            end
            PS_CU_Y:
            begin
                mul_a = sqy_reg;
                mul_b = dy_reg;
            end
            default:
            begin
                mul_a = sqz_reg;
                mul_b = dz_reg;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign mul_r     = mul_p[2*FRAC_BITS-1:FRAC_BITS];
    assign xy_full   = xc_reg * ny[XY_CW-1:0] + yc_reg;
    assign cell_full = xy_reg * nz[Z_CW-1:0] + zc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            xpos_reg <= x_pos;
            ypos_reg <= y_pos;
            zpos_reg <= z_pos;
        end
        if (cmd.loc)
        begin
            xc_reg <= lx.cell_idx[XY_IW-1:0];
            yc_reg <= ly.cell_idx[XY_IW-1:0];
            zc_reg <= lz.cell_idx[Z_IW-1:0];
            dx_reg <= lx.frac;
            dy_reg <= ly.frac;
            dz_reg <= lz.frac;
        end
        if (cmd.prep)
        begin
            case (cmd.pstep)
                PS_SQ_X:
                begin
                    sqx_reg <= mul_r;
                    xy_reg  <= xy_full[XY_W-1:0];
                end
                PS_SQ_Y:
                begin
                    sqy_reg  <= mul_r;
                    cell_reg <= cell_full[CELL_W-1:0];
                end
                PS_SQ_Z: sqz_reg <= mul_r;
                PS_CU_X: cux_reg <= mul_r;
                PS_CU_Y: cuy_reg <= mul_r;
                default: cuz_reg <= mul_r;
            endcase
        end
    end

    // Coefficient memory: loads write at the request index, the sweep reads
    // the 64 coefficients of the selected cell in order.
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [COEF_W-1:0] ram_rdata;

    assign ram_addr = cmd.ram_we ? coeff_index[ADDR_W-1:0] : {cell_reg, cmd.idx};
    assign ram_we   = cmd.ram_we && ({1'b0, coeff_index} < (IDX_W + 1)'(STORE_DEPTH));

    tse_ram #(
        .WIDTH (COEF_W),
        .DEPTH (RAM_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (coeff_value),
        .rdata (ram_rdata)
    );

    // Stage 1: x*y partial products, alongside the memory read.
    logic [1:0]       ei;
    logic [1:0]       ej;
    logic [1:0]       ek;
    logic [P_W-1:0]   pxi;
    logic [P_W-1:0]   pxm;
    logic [P_W-1:0]   pyj;
    logic [P_W-1:0]   pym;
    logic [2*P_W-1:0] s1_pf_reg;
    logic [2*P_W-1:0] s1_px_reg;
    logic [2*P_W-1:0] s1_py_reg;
    logic [P_W-1:0]   s1_pzk_reg;
    logic [P_W-1:0]   s1_pzm_reg;
    logic [1:0]       s1_i_reg;
    logic [1:0]       s1_j_reg;
    logic [1:0]       s1_k_reg;

    assign ei  = cmd.idx[5:4];
    assign ej  = cmd.idx[3:2];
    assign ek  = cmd.idx[1:0];
    // At exponent zero the lower power wraps around, but its weight is zero.
    assign pxi = pow_sel(ei, dx_reg, sqx_reg, cux_reg);
    assign pxm = pow_sel(ei - 2'd1, dx_reg, sqx_reg, cux_reg);
    assign pyj = pow_sel(ej, dy_reg, sqy_reg, cuy_reg);
    assign pym = pow_sel(ej - 2'd1, dy_reg, sqy_reg, cuy_reg);

    always_ff @(posedge clk)
    begin
        s1_pf_reg  <= pxi * pyj;
        s1_px_reg  <= pxm * pyj;
        s1_py_reg  <= pxi * pym;
        s1_pzk_reg <= pow_sel(ek, dz_reg, sqz_reg, cuz_reg);
        s1_pzm_reg <= pow_sel(ek - 2'd1, dz_reg, sqz_reg, cuz_reg);
        s1_i_reg   <= ei;
        s1_j_reg   <= ej;
        s1_k_reg   <= ek;
    end

    // Stage 2: monomials, and capture of the coefficient.
    logic [2*P_W-1:0]         m_f;
    logic [2*P_W-1:0]         m_x;
    logic [2*P_W-1:0]         m_y;
    logic [2*P_W-1:0]         m_z;
    logic [P_W-1:0]           s2_mf_reg;
    logic [P_W-1:0]           s2_mx_reg;
    logic [P_W-1:0]           s2_my_reg;
    logic [P_W-1:0]           s2_mz_reg;
    logic [1:0]               s2_i_reg;
    logic [1:0]               s2_j_reg;
    logic [1:0]               s2_k_reg;
    logic signed [COEF_W-1:0] s2_coef_reg;

    assign m_f = s1_pf_reg[2*FRAC_BITS:FRAC_BITS] * s1_pzk_reg;
    assign m_x = s1_px_reg[2*FRAC_BITS:FRAC_BITS] * s1_pzk_reg;
    assign m_y = s1_py_reg[2*FRAC_BITS:FRAC_BITS] * s1_pzk_reg;
    assign m_z = s1_pf_reg[2*FRAC_BITS:FRAC_BITS] * s1_pzm_reg;

    always_ff @(posedge clk)
    begin
        s2_mf_reg   <= m_f[2*FRAC_BITS:FRAC_BITS];
        s2_mx_reg   <= m_x[2*FRAC_BITS:FRAC_BITS];
        s2_my_reg   <= m_y[2*FRAC_BITS:FRAC_BITS];
        s2_mz_reg   <= m_z[2*FRAC_BITS:FRAC_BITS];
        s2_i_reg    <= s1_i_reg;
        s2_j_reg    <= s1_j_reg;
        s2_k_reg    <= s1_k_reg;
        s2_coef_reg <= $signed(ram_rdata);
    end

    // Stage 3: weights times coefficient.
    logic [W_W-1:0]           w_f;
    logic [W_W-1:0]           w_x;
    logic [W_W-1:0]           w_y;
    logic [W_W-1:0]           w_z;
    logic signed [PROD_W-1:0] s3_pf_reg;
    logic signed [PROD_W-1:0] s3_px_reg;
    logic signed [PROD_W-1:0] s3_py_reg;
    logic signed [PROD_W-1:0] s3_pz_reg;

    assign w_f = {1'b0, s2_mf_reg};
    assign w_x = times_exp(s2_mx_reg, s2_i_reg);
    assign w_y = times_exp(s2_my_reg, s2_j_reg);
    assign w_z = times_exp(s2_mz_reg, s2_k_reg);

    always_ff @(posedge clk)
    begin
        s3_pf_reg <= s2_coef_reg * $signed({1'b0, w_f});
        s3_px_reg <= s2_coef_reg * $signed({1'b0, w_x});
        s3_py_reg <= s2_coef_reg * $signed({1'b0, w_y});
        s3_pz_reg <= s2_coef_reg * $signed({1'b0, w_z});
    end

    // Valid flags follow each issued coefficient through the three stages.
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 4: exact accumulation.
    logic signed [ACC_W-1:0] acc_f_reg;
    logic signed [ACC_W-1:0] acc_x_reg;
    logic signed [ACC_W-1:0] acc_y_reg;
    logic signed [ACC_W-1:0] acc_z_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            acc_f_reg <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_f_reg <= acc_f_reg + ACC_W'(s3_pf_reg);
            acc_x_reg <= acc_x_reg + ACC_W'(s3_px_reg);
            acc_y_reg <= acc_y_reg + ACC_W'(s3_py_reg);
            acc_z_reg <= acc_z_reg + ACC_W'(s3_pz_reg);
        end
    end

    // Dropping the fraction bits of the two's complement sum rounds toward
    // minus infinity.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            spline_value <= acc_f_reg[ACC_W-1:FRAC_BITS];
            deriv_x      <= acc_x_reg[ACC_W-1:FRAC_BITS];
            deriv_y      <= acc_y_reg[ACC_W-1:FRAC_BITS];
            deriv_z      <= acc_z_reg[ACC_W-1:FRAC_BITS];
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the tricubic spline evaluator. Coefficients are
// loaded over the input stream, points are evaluated under several grid sizes,
// and every result is compared against a fixed-point predictor of the block.
// ----------------------------------------------------------------------------
module tb;
    import tse_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     RESET_CYCLES  = 10;
    // Long enough to cover an evaluate transaction still in flight.
    localparam int     SETTLE_CYCLES = 100;
    // Slowest legal run is about 2000 transactions, each with the longest gap and stall.
    localparam longint CYCLE_LIMIT   = 1200000;
    localparam int     RANDOM_ITEMS  = 1300;
    localparam int     NUM_PHASES    = 8;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     MAX_REPORTS   = 10;

    typedef enum int {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

    typedef struct packed {
        logic [OUT_W-1:0] deriv_z;
        logic [OUT_W-1:0] deriv_y;
        logic [OUT_W-1:0] deriv_x;
        logic [OUT_W-1:0] value;
    } spline_out_t;

    class spline_scoreboard;
        bit [COEF_W-1:0] coeff_mem [STORE_DEPTH];
        bit [4:0]        x_reg;
        bit [4:0]        y_reg;
        bit [3:0]        z_reg;
        spline_out_t     expected_q [$];
        int unsigned     mismatches;

        function new();
            x_reg      = 5'd16;
            y_reg      = 5'd16;
            z_reg      = 4'd8;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [4:0] data);
            case (idx)
                CFG_X_CELLS: x_reg = data;
                CFG_Y_CELLS: y_reg = data;
                CFG_Z_CELLS: z_reg = data[3:0];
                default:     ;
            endcase
        endfunction

        // Register value of zero acts as one, values above the maximum saturate.
        function int unsigned cells(axis_t axis);
            int unsigned r;
            int unsigned m;
            r = (axis == AXIS_X) ? x_reg : (axis == AXIS_Y) ? y_reg : z_reg;
            m = (axis == AXIS_Z) ? MAX_Z_CELLS : MAX_XY_CELLS;
            if (r == 0)
                r = 1;
            else if (r > m)
                r = m;
            return r;
        endfunction

        function void split(logic [POS_W-1:0] pos, int unsigned n,
                            output int unsigned cell_idx, output longint unsigned frac);
            longint unsigned p;
            longint unsigned lim;
            lim = longint'(n) << FRAC_BITS;
            p   = pos;
            if (p > lim)
                p = lim;
            cell_idx = 32'(p >> FRAC_BITS);
            frac     = p & ((64'd1 << FRAC_BITS) - 1);
            if (cell_idx >= n)
                cell_idx = n - 1;
        endfunction

        function int unsigned cell_base(logic [POS_W-1:0] xp, logic [POS_W-1:0] yp,
                                        logic [POS_W-1:0] zp);
            int unsigned     ny;
            int unsigned     nz;
            int unsigned     cx;
            int unsigned     cy;
            int unsigned     cz;
            longint unsigned f;
            ny = cells(AXIS_Y);
            nz = cells(AXIS_Z);
            split(xp, cells(AXIS_X), cx, f);
            split(yp, ny, cy, f);
            split(zp, nz, cz, f);
            return ((cx * ny + cy) * nz + cz) * COEFS_PER_CELL;
        endfunction

        function logic [OUT_W-1:0] to_out(longint s);
            longint t;
            t = s >>> FRAC_BITS;
            return t[OUT_W-1:0];
        endfunction

        function spline_out_t evaluate(logic [POS_W-1:0] xp, logic [POS_W-1:0] yp,
                                       logic [POS_W-1:0] zp);
            longint unsigned d [3];
            longint unsigned pw [3][4];
            longint unsigned mono [4][4][4];
            longint unsigned wx;
            longint unsigned wy;
            longint unsigned wz;
            longint          c;
            longint          s_val;
            longint          s_x;
            longint          s_y;
            longint          s_z;
            int unsigned     unused_cell;
            int unsigned     base;
            spline_out_t     r;
            split(xp, cells(AXIS_X), unused_cell, d[0]);
            split(yp, cells(AXIS_Y), unused_cell, d[1]);
            split(zp, cells(AXIS_Z), unused_cell, d[2]);
            for (int a = 0; a < 3; a++)
            begin
                pw[a][0] = 64'd1 << FRAC_BITS;
                pw[a][1] = d[a];
                pw[a][2] = (d[a] * d[a]) >> FRAC_BITS;
                pw[a][3] = (pw[a][2] * d[a]) >> FRAC_BITS;
            end
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    for (int k = 0; k < 4; k++)
                        mono[i][j][k] = (((pw[0][i] * pw[1][j]) >> FRAC_BITS) * pw[2][k])
                                        >> FRAC_BITS;
            base  = cell_base(xp, yp, zp);
            s_val = 0;
            s_x   = 0;
            s_y   = 0;
            s_z   = 0;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    for (int k = 0; k < 4; k++)
                    begin
                        c  = longint'($signed(coeff_mem[base + i * 16 + j * 4 + k]));
                        wx = (i > 0) ? i * mono[i-1][j][k] : 0;
                        wy = (j > 0) ? j * mono[i][j-1][k] : 0;
                        wz = (k > 0) ? k * mono[i][j][k-1] : 0;
                        s_val += c * longint'(mono[i][j][k]);
                        s_x   += c * longint'(wx);
                        s_y   += c * longint'(wy);
                        s_z   += c * longint'(wz);
                    end
            r.value   = to_out(s_val);
            r.deriv_x = to_out(s_x);
            r.deriv_y = to_out(s_y);
            r.deriv_z = to_out(s_z);
            return r;
        endfunction

        function void note_request(logic kind, logic [IDX_W-1:0] idx,
                                   logic [COEF_W-1:0] val, logic [POS_W-1:0] xp,
                                   logic [POS_W-1:0] yp, logic [POS_W-1:0] zp);
            if (kind == REQ_LOAD)
            begin
                if (idx < STORE_DEPTH)
                    coeff_mem[idx] = val;
            end
            else
                expected_q.push_back(evaluate(xp, yp, zp));
        endfunction

        function void report(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s: expected %h, got %h", what, want, got);
        endfunction

        function void check_result(spline_out_t got);
            spline_out_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing pending: %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (want.value !== got.value)
                report("spline_value", want.value, got.value);
            if (want.deriv_x !== got.deriv_x)
                report("deriv_x", want.deriv_x, got.deriv_x);
            if (want.deriv_y !== got.deriv_y)
                report("deriv_y", want.deriv_y, got.deriv_y);
            if (want.deriv_z !== got.deriv_z)
                report("deriv_z", want.deriv_z, got.deriv_z);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [127:0]       s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [167:0]       m_tdata;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IW-1:0]  cfg_index;
    logic [4:0]         cfg_data;

    spline_scoreboard   sb = new();
    bit                 written [STORE_DEPTH];
    int unsigned        accepted_items;
    bit                 tx_steady;
    bit                 rx_steady;
    int unsigned        hold_request;
    longint             cycle_count;

    int unsigned phase_x [NUM_PHASES] = '{1, 2, 16, 5, 31, 16, 3, 0};
    int unsigned phase_y [NUM_PHASES] = '{1, 3, 16, 7, 20, 1, 16, 9};
    int unsigned phase_z [NUM_PHASES] = '{1, 1, 8, 3, 24, 8, 2, 4};

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    tricubic_spline_eval_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function logic [COEF_W-1:0] rand_coeff();
        int unsigned r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        v = $urandom;
        if (r < 70)
            return v;
        else if (r < 80)
            return 32'h7FFF_FFFF;
        else if (r < 90)
            return 32'h8000_0000;
        return {{15{v[16]}}, v[16:0]};
    endfunction

    // Mostly the first and last cell of an axis, with the edge and beyond it.
    function logic [POS_W-1:0] pick_coord(int unsigned n);
        int unsigned r;
        logic [15:0] f;
        r = $urandom_range(0, 99);
        f = $urandom;
        if (r < 40)
            return {8'd0, f};
        else if (r < 70)
            return POS_W'(((n - 1) << FRAC_BITS) | f);
        else if (r < 78)
            return POS_W'(n << FRAC_BITS);
        else if (r < 86)
            return POS_W'($urandom_range(n << FRAC_BITS, 24'hFF_FFFF));
        else if (r < 92)
            return POS_W'((($urandom_range(0, 1) * (n - 1)) << FRAC_BITS)
                          | ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000));
        return POS_W'(($urandom_range(0, n - 1) << FRAC_BITS) | f);
    endfunction

    task automatic idle_gap();
        int unsigned r;
        int unsigned g;
        if (tx_steady)
            return;
        r = $urandom_range(0, 99);
        if (r < 60)
            g = 0;
        else if (r < 90)
            g = $urandom_range(1, 3);
        else if (r < 98)
            g = $urandom_range(4, 12);
        else
            g = $urandom_range(20, 40);
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_item(logic kind, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val,
                             logic [POS_W-1:0] xp, logic [POS_W-1:0] yp,
                             logic [POS_W-1:0] zp);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, zp, yp, xp, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(kind, idx, val, xp, yp, zp);
        if (kind == REQ_LOAD)
            written[idx] = 1'b1;
        accepted_items++;
        idle_gap();
    endtask

    task automatic load_item(int unsigned addr, logic [COEF_W-1:0] val);
        send_item(REQ_LOAD, IDX_W'(addr), val, POS_W'($urandom), POS_W'($urandom),
                  POS_W'($urandom));
    endtask

    // Stop offering and let every pending evaluate and any in-flight load finish.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [4:0] data, bit keep);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        if (!keep)
            cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(int unsigned x, int unsigned y, int unsigned z);
        cfg_write(CFG_X_CELLS, 5'(x), 1'b1);
        cfg_write(CFG_Y_CELLS, 5'(y), 1'b1);
        cfg_write(CFG_Z_CELLS, 5'(z), 1'b0);
    endtask

    task automatic set_cell(int unsigned base, logic [COEF_W-1:0] val);
        for (int i = 0; i < COEFS_PER_CELL; i++)
            load_item(base + i, val);
    endtask

    // Evaluates read a whole cell, so any coefficient never loaded gets one first.
    task automatic eval_point(logic [POS_W-1:0] xp, logic [POS_W-1:0] yp,
                              logic [POS_W-1:0] zp);
        int unsigned base;
        base = sb.cell_base(xp, yp, zp);
        for (int i = 0; i < COEFS_PER_CELL; i++)
            if (!written[base + i])
                load_item(base + i, rand_coeff());
        send_item(REQ_EVAL, IDX_W'($urandom), $urandom, xp, yp, zp);
    endtask

    task automatic random_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            eval_point(pick_coord(sb.cells(AXIS_X)), pick_coord(sb.cells(AXIS_Y)),
                       pick_coord(sb.cells(AXIS_Z)));
        else if (r < 85)
            load_item(IDX_W'($urandom), rand_coeff());
        else
            load_item($urandom_range(0, COEFS_PER_CELL - 1), rand_coeff());
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int unsigned stall_left;
        int unsigned r;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_request != 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!rx_steady && $urandom_range(0, 99) < 20)
            begin
                r          = $urandom_range(0, 99);
                stall_left = (r < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned phase_start;
        bit          paused;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tuser      <= REQ_LOAD;
        s_tdata      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_X_CELLS;
        cfg_data     <= '0;
        tx_steady    = 1'b1;
        rx_steady    = 1'b1;
        hold_request = 0;
        paused       = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset grid of 16 x 16 x 8: extreme indexes and values, first and last cell.
        send_item(REQ_LOAD, '0, '0, '1, '1, '1);
        send_item(REQ_LOAD, '1, '1, '0, '0, '0);
        load_item(1, 32'h7FFF_FFFF);
        load_item(2, 32'h8000_0000);
        eval_point(24'h00_0000, 24'h00_0000, 24'h00_0000);
        eval_point(24'h00_FFFF, 24'h00_FFFF, 24'h00_FFFF);
        eval_point(24'h00_8000, 24'h00_4000, 24'h00_C000);
        eval_point(24'h10_0000, 24'h10_0000, 24'h08_0000);
        eval_point('1, '1, '1);
        eval_point(24'h0F_0000, 24'h0F_FFFF, 24'h07_ABCD);
        send_item(REQ_EVAL, '1, '1, '0, '0, '0);
        wait_drain();

        // Zero counts behave as a single cell; full-scale coefficients in it.
        set_grid(0, 0, 0);
        eval_point(24'h01_0000, 24'h01_0000, 24'h01_0000);
        eval_point('1, '1, '1);
        eval_point(24'h00_ABCD, 24'h00_1234, 24'h00_FFFF);
        set_cell(0, 32'h7FFF_FFFF);
        eval_point(24'h00_FFFF, 24'h00_FFFF, 24'h00_FFFF);
        set_cell(0, 32'h8000_0000);
        eval_point(24'h00_FFFF, 24'h00_FFFF, 24'h00_FFFF);
        eval_point(24'h01_0000, 24'h01_0000, 24'h01_0000);
        wait_drain();

        // A write past the last register changes nothing.
        cfg_write(2'd3, 5'd7, 1'b0);
        eval_point(24'h01_0000, 24'h00_8000, 24'h01_0000);
        wait_drain();

        // Oversized counts saturate, and a z count of 16 wraps to zero.
        set_grid(31, 20, 16);
        eval_point('1, '1, '1);
        eval_point(24'h0F_8000, 24'h00_0100, 24'h00_FFFF);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drain();
            set_grid(phase_x[p], phase_y[p], phase_z[p]);
            tx_steady   = (p == 3);
            rx_steady   = (p == 3 || p == 6);
            phase_start = accepted_items;
            // The output side freezes while the input keeps offering.
            if (p == 2)
                hold_request = HOLD_CYCLES;
            while (accepted_items - phase_start < RANDOM_ITEMS / NUM_PHASES)
            begin
                if (p == 5 && !paused && accepted_items - phase_start >= 80)
                begin
                    wait_drain();
                    paused = 1'b1;
                end
                random_step();
            end
        end
        wait_drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ tricubic_spline_eval_top.f @@
hdl/tse_pkg.sv
hdl/tse_ram.sv
hdl/tse_ctrl.sv
hdl/tse_dp.sv
hdl/tricubic_spline_eval_top.sv
tb/sv/tb.sv
